>>> hw/rtl/delta_list_timer_queue_assert.svh
// assertion macros for the delta list timer queue checker
// expects clk and rst_n in the scope where a macro is used
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DLTQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dltq check failed");

// next-cycle implication, disabled while in reset
`define DLTQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dltq check failed");

`endif

>>> hw/rtl/dltq_pkg.sv
// shared types and constants of the delta list timer queue
// no dependencies
package dltq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int DELAY_BITS_DEF  = 32;
    localparam int ID_W            = 4;
    localparam int ID_COUNT        = 16;
    localparam int AMOUNT_W        = 32;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_TICK   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_QUEUED     = 2'd1,
        ST_NOT_QUEUED = 2'd2
    } status_t;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_FIX,
        S_SHF_RD,
        S_SHF_WR,
        S_INS_PUT,
        S_RESP,
        S_REM_RD,
        S_REM_CMP,
        S_REM_SRD,
        S_REM_ADD,
        S_RSH_RD,
        S_RSH_WR,
        S_REM_END,
        S_TCK_RD,
        S_TCK_CMP,
        S_TCK_FIX,
        S_TCK_LAST,
        S_CMP_RD,
        S_CMP_WR
    } seq_state_t;

endpackage

>>> hw/rtl/dltq_ifs.sv
// valid/ready channel interfaces for command and result transactions
// depends on dltq_pkg
interface dltq_in_if import dltq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     timer_id;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output kind, output timer_id, output amount, input ready);
    modport sink   (input valid, input kind, input timer_id, input amount, output ready);
endinterface

interface dltq_out_if import dltq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     result_id;
    logic                expired;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output result_id, output expired, output status,
                    output last, input ready);
    modport sink   (input valid, input result_id, input expired, input status,
                    input last, output ready);
endinterface

>>> hw/rtl/dltq_alu.sv
// shared add/subtract unit with borrow used for every delta update and compare
// depends on dltq_pkg
module dltq_alu import dltq_pkg::*; #(
    parameter int W = DELAY_BITS_DEF
) (
    input  alu_op_t      op,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] y,
    output logic         borrow
);

    logic [W:0] full;

    always_comb
    begin
        if (op == ALU_ADD)
        begin
            full = {1'b0, a} + {1'b0, b};
        end
        else
        begin
            full = {1'b0, a} - {1'b0, b};
        end
    end

    assign y      = full[W-1:0];
    // a < b when the subtraction wraps
    assign borrow = (op == ALU_SUB) && full[W];

endmodule

>>> hw/rtl/dltq_mem.sv
// slot store: one write port, one read port with registered read data
// depends on dltq_pkg
module dltq_mem import dltq_pkg::*; #(
    parameter int DEPTH = TIMER_SLOTS_DEF,
    parameter int WIDTH = ID_W + DELAY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/delta_list_timer_queue.sv
// delta list timer queue: top level with the slot sequencer
// depends on dltq_pkg, dltq_ifs, dltq_alu and dltq_mem
//
// Holds up to TIMER_SLOTS numbered timers (ids 0..15) in expiry order; each
// slot stores only its delay beyond the slot in front of it. A command
// transaction on item is insert (kind 0), remove (kind 1) or tick (kind 2);
// kind 3 is dropped with no result. Insert and remove give one result with
// status ok, already queued or not queued. A tick gives one result per
// expired timer with expired set, last marking the final one, and nothing at
// all when no timer expires. Delays and gaps are unsigned and taken modulo
// 2^DELAY_BITS. item.ready is high only while the sequencer is idle, so one
// command is processed at a time; the result sits in an output register, so
// a new command is taken while the previous result waits. All slot work goes
// through one memory with a registered read port and one shared add/subtract
// unit; each slot visited is read, then compared or written. Insert walks
// and shifts slots, remove searches and shifts them, tick visits the expired
// slots and moves the remaining ones; each also waits while the result side
// stalls. The slot memory needs no clearing after reset: only slots below
// the queue length are ever read.
module delta_list_timer_queue import dltq_pkg::*; #(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
    parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dltq_in_if.sink    item,
    dltq_out_if.source result
);

    localparam int ADDR_W  = $clog2(TIMER_SLOTS);
    localparam int LEN_W   = $clog2(TIMER_SLOTS + 1);
    localparam int ENTRY_W = ID_W + DELAY_BITS;
    localparam int CUT_W   = (DELAY_BITS < AMOUNT_W) ? DELAY_BITS : AMOUNT_W;

    // sequencer state and working registers
    seq_state_t            state_reg, state_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [DELAY_BITS-1:0] rest_reg, rest_next;   // remaining delay or gap
    logic [DELAY_BITS-1:0] save_reg, save_next;   // delta of the removed slot
    logic [LEN_W-1:0]      idx_reg, idx_next;
    logic [LEN_W-1:0]      pos_reg, pos_next;     // insert point, removed slot, expire count
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [ID_COUNT-1:0]   mask_reg, mask_next;
    status_t               status_reg, status_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]       pend_id_reg, pend_id_next;

    // output register
    logic                  out_valid_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic                  out_expired_reg;
    status_t               out_status_reg;
    logic                  out_last_reg;
    logic                  out_load;
    logic [ID_W-1:0]       load_id;
    logic                  load_expired;
    status_t               load_status;
    logic                  load_last;
    logic                  out_free;

    // slot memory
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic [ID_W-1:0]       rd_timer;
    logic [DELAY_BITS-1:0] rd_delta;

    // shared arithmetic
    alu_op_t               alu_op;
    logic [DELAY_BITS-1:0] alu_a;
    logic [DELAY_BITS-1:0] alu_b;
    logic [DELAY_BITS-1:0] alu_y;
    logic                  alu_borrow;

    logic [LEN_W-1:0]      idx_inc;
    logic [LEN_W-1:0]      idx_dec;
    logic [LEN_W-1:0]      src_idx;               // compaction source slot

    assign rd_timer = rd_data[ENTRY_W-1:DELAY_BITS];
    assign rd_delta = rd_data[DELAY_BITS-1:0];
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign src_idx  = idx_reg + pos_reg;
    assign out_free = !out_valid_reg || result.ready;

    assign item.ready = (state_reg == S_IDLE);

    dltq_mem #(
        .DEPTH (TIMER_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_dltq_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dltq_alu #(
        .W (DELAY_BITS)
    ) u_dltq_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            mask_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            mask_reg       <= mask_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        rest_reg    <= rest_next;
        save_reg    <= save_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        pend_id_reg <= pend_id_next;
        if (out_load)
        begin
            out_id_reg      <= load_id;
            out_expired_reg <= load_expired;
            out_status_reg  <= load_status;
            out_last_reg    <= load_last;
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        id_next         = id_reg;
        rest_next       = rest_reg;
        save_next       = save_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        mask_next       = mask_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;

        out_load     = 1'b0;
        load_id      = id_reg;
        load_expired = 1'b0;
        load_status  = status_reg;
        load_last    = 1'b1;

        wr_en   = 1'b0;
        wr_addr = idx_reg[ADDR_W-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = idx_reg[ADDR_W-1:0];

        // default: remaining delay minus slot delta
        alu_op = ALU_SUB;
        alu_a  = rest_reg;
        alu_b  = rd_delta;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    id_next         = item.timer_id;
                    rest_next       = DELAY_BITS'(item.amount[CUT_W-1:0]);
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    unique case (item.kind)
                        KIND_INSERT:
                        begin
                            if (mask_reg[item.timer_id] || (len_reg >= LEN_W'(TIMER_SLOTS)))
                            begin
                                status_next = ST_QUEUED;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (!mask_reg[item.timer_id])
                            begin
                                status_next = ST_NOT_QUEUED;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_REM_RD;
                            end
                        end
                        KIND_TICK:
                        begin
                            state_next = S_TCK_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // insert: walk until the remaining delay is below a slot delta
            S_INS_RD:
            begin
                if (idx_reg == len_reg)
                begin
                    pos_next   = idx_reg;
                    state_next = S_SHF_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (alu_borrow)
                begin
                    pos_next   = idx_reg;
                    state_next = S_INS_FIX;
                end
                else
                begin
                    rest_next  = alu_y;
                    idx_next   = idx_inc;
                    state_next = S_INS_RD;
                end
            end
            S_INS_FIX:
            begin
                // the slot behind the new one gives up the new delay
                alu_a      = rd_delta;
                alu_b      = rest_reg;
                wr_en      = 1'b1;
                wr_data    = {rd_timer, alu_y};
                idx_next   = len_reg;
                state_next = S_SHF_RD;
            end
            S_SHF_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[ADDR_W-1:0];
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_dec;
                state_next = S_SHF_RD;
            end
            S_INS_PUT:
            begin
                wr_en             = 1'b1;
                wr_addr           = pos_reg[ADDR_W-1:0];
                wr_data           = {id_reg, rest_reg};
                len_next          = len_reg + 1'b1;
                mask_next[id_reg] = 1'b1;
                status_next       = ST_OK;
                state_next        = S_RESP;
            end

            // acknowledge of insert or remove
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // remove: find the slot, credit its successor, close the gap
            S_REM_RD:
            begin
                if (idx_reg == len_reg)
                begin
                    mask_next[id_reg] = 1'b0;
                    status_next       = ST_NOT_QUEUED;
                    state_next        = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_REM_CMP;
                end
            end
            S_REM_CMP:
            begin
                idx_next = idx_inc;
                if (rd_timer == id_reg)
                begin
                    pos_next   = idx_reg;
                    save_next  = rd_delta;
                    state_next = S_REM_SRD;
                end
                else
                begin
                    state_next = S_REM_RD;
                end
            end
            S_REM_SRD:
            begin
                if (idx_reg == len_reg)
                begin
                    state_next = S_REM_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_REM_ADD;
                end
            end
            S_REM_ADD:
            begin
                alu_op     = ALU_ADD;
                alu_a      = save_reg;
                alu_b      = rd_delta;
                wr_en      = 1'b1;
                wr_data    = {rd_timer, alu_y};
                idx_next   = pos_reg;
                state_next = S_RSH_RD;
            end
            S_RSH_RD:
            begin
                if (idx_inc == len_reg)
                begin
                    state_next = S_REM_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[ADDR_W-1:0];
                    state_next = S_RSH_WR;
                end
            end
            S_RSH_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_RSH_RD;
            end
            S_REM_END:
            begin
                len_next          = len_reg - 1'b1;
                mask_next[id_reg] = 1'b0;
                status_next       = ST_OK;
                state_next        = S_RESP;
            end

            // tick: expire front slots, one expired id held back to mark last
            S_TCK_RD:
            begin
                if (idx_reg == len_reg)
                begin
                    state_next = S_TCK_LAST;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_TCK_CMP;
                end
            end
            S_TCK_CMP:
            begin
                if (alu_borrow)
                begin
                    state_next = S_TCK_FIX;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load     = 1'b1;
                        load_id      = pend_id_reg;
                        load_expired = 1'b1;
                        load_status  = ST_OK;
                        load_last    = 1'b0;
                    end
                    pend_valid_next     = 1'b1;
                    pend_id_next        = rd_timer;
                    mask_next[rd_timer] = 1'b0;
                    rest_next           = alu_y;
                    idx_next            = idx_inc;
                    state_next          = S_TCK_RD;
                end
            end
            S_TCK_FIX:
            begin
                // first survivor keeps what is left of its delta
                alu_a      = rd_delta;
                alu_b      = rest_reg;
                wr_en      = 1'b1;
                wr_data    = {rd_timer, alu_y};
                state_next = S_TCK_LAST;
            end
            S_TCK_LAST:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load     = 1'b1;
                        load_id      = pend_id_reg;
                        load_expired = 1'b1;
                        load_status  = ST_OK;
                        load_last    = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    pos_next        = idx_reg;
                    idx_next        = '0;
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_CMP_RD;
                    end
                end
            end
            S_CMP_RD:
            begin
                if (src_idx == len_reg)
                begin
                    len_next   = len_reg - pos_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = src_idx[ADDR_W-1:0];
                    state_next = S_CMP_WR;
                end
            end
            S_CMP_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_CMP_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.valid     = out_valid_reg;
    assign result.result_id = out_id_reg;
    assign result.expired   = out_expired_reg;
    assign result.status    = out_status_reg;
    assign result.last      = out_last_reg;

endmodule

>>> hw/rtl/dltq_checker.sv
// port-level checks of the delta list timer queue, bound to the top level
// depends on dltq_pkg and delta_list_timer_queue_assert.svh
`include "delta_list_timer_queue_assert.svh"

module dltq_checker import dltq_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input logic                result_expired,
    input logic                result_last,
    input logic [STATUS_W-1:0] result_status
);

    // a pending result transaction is not withdrawn
    `DLTQ_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid)

    // only tick expiries come in groups
    `DLTQ_ASSERT_IMP(a_group_is_expiry, result_valid && !result_last, result_expired)

    // an expiry never carries an error status
    `DLTQ_ASSERT_IMP(a_expiry_ok, result_valid && result_expired,
                     result_status == STATUS_W'(ST_OK))

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_expired (result.expired),
    .result_last    (result.last),
    .result_status  (result.status)
);
